[rtl/core/ready_queue_scheduler_macros.svh]
// Assertion macros used by the checker file
`ifndef READY_QUEUE_SCHEDULER_MACROS_SVH
`define READY_QUEUE_SCHEDULER_MACROS_SVH

// Clocked implication with reset disable
`define RQS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication with reset disable
`define RQS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/rqs_pkg.sv]
package rqs_pkg;
	localparam int QueueDepth = 8;
	localparam int AddrWidth  = 10;
	localparam int PidWidth   = 8;
	localparam int PosWidth   = $clog2(QueueDepth);
	localparam int CntWidth   = $clog2(QueueDepth + 1);

	localparam logic [1:0] KIND_ADMIT = 2'd0;
	localparam logic [1:0] KIND_STEP  = 2'd1;
	localparam logic [1:0] KIND_ABORT = 2'd2;

	localparam logic [1:0] POL_FCFS  = 2'd0;
	localparam logic [1:0] POL_RR    = 2'd1;
	localparam logic [1:0] POL_SJF   = 2'd2;
	localparam logic [1:0] POL_AGING = 2'd3;

	localparam logic CFG_POLICY  = 1'b0;
	localparam logic CFG_QUANTUM = 1'b1;

	typedef struct packed {
		logic [PidWidth-1:0]  pid;
		logic [AddrWidth-1:0] start;
		logic [AddrWidth-1:0] length;
		logic [AddrWidth-1:0] progress;
		logic [AddrWidth-1:0] estimate;
	} slot_t;

	// Operation applied to every cell of the row in the same cycle
	typedef enum logic [2:0] {
		OP_HOLD, OP_LOAD, OP_REMOVE, OP_PROMOTE, OP_ISSUE, OP_AGE, OP_CLEAR
	} row_op_t;

	typedef struct packed {
		row_op_t             op;
		logic [PosWidth-1:0] sel;
		logic [PosWidth-1:0] last;
		slot_t               data;
	} row_ctl_t;
endpackage

[rtl/core/rqs_cell.sv]
module rqs_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [rqs_pkg::PosWidth-1:0] pos,
	input  rqs_pkg::row_ctl_t      ctl,
	input  rqs_pkg::slot_t         up_slot,
	input  logic                   up_valid,
	input  rqs_pkg::slot_t         head_slot,
	output rqs_pkg::slot_t         slot,
	output logic                   valid
);
	import rqs_pkg::*;

	slot_t slot_q;
	logic  valid_q;

	assign slot  = slot_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_LOAD: if (pos == ctl.sel) valid_q <= 1'b1;
				OP_REMOVE: if (pos >= ctl.sel) valid_q <= up_valid && pos != ctl.last;
				OP_CLEAR: valid_q <= 1'b0;
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: if (pos == ctl.sel) slot_q <= ctl.data;
			OP_REMOVE: if (pos >= ctl.sel && pos != ctl.last) slot_q <= up_slot;
			OP_PROMOTE: begin
				// chosen one to head, gap closes, old head to tail
				if (pos == '0) slot_q <= ctl.data;
				else if (pos == ctl.last) slot_q <= head_slot;
				else if (pos >= ctl.sel) slot_q <= up_slot;
			end
			OP_ISSUE: if (pos == ctl.sel) slot_q.progress <= slot_q.progress + 1'b1;
			OP_AGE: if (pos != '0 && valid_q && slot_q.estimate != '0)
				slot_q.estimate <= slot_q.estimate - 1'b1;
			default: slot_q <= slot_q;
		endcase
	end
endmodule

[rtl/core/rqs_row.sv]
module rqs_row (
	input  logic              clk,
	input  logic              arst_n,
	input  rqs_pkg::row_ctl_t ctl,
	output rqs_pkg::slot_t    slots [rqs_pkg::QueueDepth],
	output logic [rqs_pkg::QueueDepth-1:0] valids
);
	import rqs_pkg::*;

	slot_t up_slot [QueueDepth];
	logic  up_valid [QueueDepth];

	for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
		if (g == QueueDepth - 1) begin : g_end
			assign up_slot[g]  = slots[g];
			assign up_valid[g] = 1'b0;
		end else begin : g_mid
			assign up_slot[g]  = slots[g+1];
			assign up_valid[g] = valids[g+1];
		end
		rqs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.pos      (PosWidth'(g)),
			.ctl      (ctl),
			.up_slot  (up_slot[g]),
			.up_valid (up_valid[g]),
			.head_slot(slots[0]),
			.slot     (slots[g]),
			.valid    (valids[g])
		);
	end
endmodule

[rtl/core/ready_queue_scheduler.sv]
// Path: abort, a rejected admit, a step on an empty queue and ignored kinds
// go straight to output; an admit goes through the scan state, a step through
// issue and finish, with a scan of the live entries first for shortest-job
// (unless locked) and aging, and an estimate update after finish for aging.
// One item at a time; the next item is taken the cycle after the result is accepted.
// Reset: asynchronous, active low; queue empty, policy FCFS, quantum 2.
module ready_queue_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // proc_start[9:0], proc_length[19:10], zero
	input  logic [1:0]  s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // instr_addr[9:0], proc_id[17:10], zero
	output logic [4:0]  m_axis_tuser,  // issued, proc_done, admit_ok, queue_empty, zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	import rqs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_ISSUE, ST_FIN, ST_AGE, ST_OUT
	} state_t;

	state_t state_q;
	logic [1:0] policy_q;
	logic [3:0] quantum_q;
	logic [PosWidth-1:0] rr_pos_q, lock_q, best_q, scan_q, sel_q;
	logic [3:0] slice_q;
	logic locked_q;
	logic [1:0] kind_q;
	logic [AddrWidth-1:0] start_q, len_q;
	logic [CntWidth-1:0] cnt_q;
	logic done_q;
	logic o_valid_q, o_issued_q, o_done_q, o_admit_q;
	logic [AddrWidth-1:0] o_addr_q;
	logic [PidWidth-1:0] o_pid_q;
	row_ctl_t ctl;
	slot_t slots [QueueDepth];
	logic [QueueDepth-1:0] valids;
	logic [CntWidth-1:0] n;
	logic [3:0] qeff;
	slot_t cur;
	logic [AddrWidth-1:0] key_scan, key_best;

	rqs_row u_row (.clk(clk), .arst_n(arst_n), .ctl(ctl), .slots(slots), .valids(valids));

	// live entries are contiguous from the head
	always_comb begin
		n = '0;
		for (int i = 0; i < QueueDepth; i++) if (valids[i]) n = CntWidth'(i + 1);
	end

	assign qeff = (quantum_q == '0) ? 4'd1 : quantum_q;
	assign cur = slots[sel_q];
	assign key_scan = (policy_q == POL_SJF) ? slots[scan_q].length : slots[scan_q].estimate;
	assign key_best = (policy_q == POL_SJF) ? slots[best_q].length : slots[best_q].estimate;

	assign s_axis_tready = (state_q == ST_IDLE) && !o_valid_q;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tdata = {6'd0, o_pid_q, o_addr_q};
	assign m_axis_tuser = {1'b0, (n == '0), o_admit_q, o_done_q, o_issued_q};

	always_comb begin
		ctl = '{op: OP_HOLD, sel: sel_q, last: PosWidth'(cnt_q - 1'b1), data: slots[sel_q]};
		case (state_q)
			ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == KIND_ABORT) ctl.op = OP_CLEAR;
			end
			ST_SCAN: if (kind_q == KIND_ADMIT) begin
				ctl.op = OP_LOAD;
				ctl.sel = PosWidth'(cnt_q);
				ctl.data = '{pid: (cnt_q == '0) ? PidWidth'(1) :
					slots[PosWidth'(cnt_q - 1'b1)].pid + 1'b1,
					start: start_q, length: len_q, progress: '0, estimate: len_q};
			end else if (scan_q == PosWidth'(cnt_q - 1'b1) && policy_q == POL_AGING
				&& best_q != '0 && !(key_scan < key_best)) begin
				ctl.op = OP_PROMOTE;
				ctl.sel = best_q;
				ctl.data = slots[best_q];
			end else if (scan_q == PosWidth'(cnt_q - 1'b1) && policy_q == POL_AGING
				&& key_scan < key_best && scan_q != '0) begin
				ctl.op = OP_PROMOTE;
				ctl.sel = scan_q;
				ctl.data = slots[scan_q];
			end
			ST_ISSUE: ctl.op = OP_ISSUE;
			ST_FIN: if (done_q) begin
				ctl.op = OP_REMOVE;
			end
			ST_AGE: ctl.op = OP_AGE;
			default: ctl.op = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			policy_q <= POL_FCFS;
			quantum_q <= 4'd2;
			rr_pos_q <= '0; slice_q <= '0; locked_q <= 1'b0; lock_q <= '0;
			o_valid_q <= 1'b0;
			kind_q <= KIND_ADMIT;
			o_issued_q <= 1'b0; o_done_q <= 1'b0; o_admit_q <= 1'b0;
			o_addr_q <= '0; o_pid_q <= '0;
			best_q <= '0; scan_q <= '0; sel_q <= '0; cnt_q <= '0; done_q <= 1'b0;
			start_q <= '0; len_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_POLICY) policy_q <= cfg_data[1:0];
				else quantum_q <= cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) o_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					kind_q <= s_axis_tuser;
					start_q <= s_axis_tdata[9:0];
					len_q <= s_axis_tdata[19:10];
					cnt_q <= n;
					o_issued_q <= 1'b0; o_done_q <= 1'b0; o_admit_q <= 1'b0;
					o_addr_q <= '0; o_pid_q <= '0;
					best_q <= '0; scan_q <= '0; sel_q <= '0;
					if (s_axis_tuser == KIND_ABORT) begin
						rr_pos_q <= '0; slice_q <= '0; locked_q <= 1'b0; lock_q <= '0;
						state_q <= ST_OUT;
					end else if (s_axis_tuser == KIND_ADMIT) begin
						if (n != CntWidth'(QueueDepth) && s_axis_tdata[19:10] != '0)
							state_q <= ST_SCAN;
						else state_q <= ST_OUT;
					end else if (s_axis_tuser == KIND_STEP && n != '0) begin
						case (policy_q)
							POL_FCFS: state_q <= ST_ISSUE;
							POL_RR: begin
								if ({1'b0, rr_pos_q} >= n) begin
									rr_pos_q <= '0; slice_q <= '0; sel_q <= '0;
								end else sel_q <= rr_pos_q;
								state_q <= ST_ISSUE;
							end
							POL_SJF: begin
								if (locked_q && {1'b0, lock_q} < n) begin
									sel_q <= lock_q;
									state_q <= ST_ISSUE;
								end else state_q <= ST_SCAN;
							end
							default: state_q <= ST_SCAN;
						endcase
					end else state_q <= ST_OUT;
				end
				ST_SCAN: begin
					if (kind_q == KIND_ADMIT) begin
						o_admit_q <= 1'b1;
						o_pid_q <= ctl.data.pid;
						state_q <= ST_OUT;
					end else begin
						// one cell compared per cycle
						if (key_scan < key_best) best_q <= scan_q;
						if (scan_q == PosWidth'(cnt_q - 1'b1)) begin
							if (policy_q == POL_SJF) begin
								locked_q <= 1'b1;
								lock_q <= (key_scan < key_best) ? scan_q : best_q;
								sel_q <= (key_scan < key_best) ? scan_q : best_q;
							end else sel_q <= '0;
							state_q <= ST_ISSUE;
						end else scan_q <= scan_q + 1'b1;
					end
				end
				ST_ISSUE: begin
					o_issued_q <= 1'b1;
					o_addr_q <= cur.start + cur.progress;
					o_pid_q <= cur.pid;
					done_q <= (cur.progress + 1'b1) >= cur.length;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					o_done_q <= done_q;
					if (done_q) begin
						if (rr_pos_q > sel_q) rr_pos_q <= rr_pos_q - 1'b1;
						if (locked_q) begin
							if (lock_q == sel_q) locked_q <= 1'b0;
							else if (lock_q > sel_q) lock_q <= lock_q - 1'b1;
						end
						if (policy_q == POL_RR) begin
							slice_q <= '0;
							if ({1'b0, rr_pos_q} >= cnt_q - 1'b1) rr_pos_q <= '0;
						end
					end else if (policy_q == POL_RR) begin
						if (slice_q + 1'b1 >= qeff) begin
							slice_q <= '0;
							rr_pos_q <= ({1'b0, sel_q} + 1'b1 >= cnt_q) ? '0 : sel_q + 1'b1;
						end else slice_q <= slice_q + 1'b1;
					end
					state_q <= (policy_q == POL_AGING) ? ST_AGE : ST_OUT;
				end
				ST_AGE: state_q <= ST_OUT;
				default: begin
					o_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

[rtl/core/rqs_checker.sv]
`include "ready_queue_scheduler_macros.svh"
module rqs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [4:0]  m_axis_tuser
);
	`RQS_ASSERT_IMP(a_admit_not_issue, clk, arst_n, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[2]))
	`RQS_ASSERT_IMP(a_done_needs_issue, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0])
	`RQS_ASSERT_NXT(a_one_at_a_time, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`RQS_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind ready_queue_scheduler rqs_checker u_rqs_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

[dv/ready_queue_scheduler_tb.sv]
`timescale 1ns / 1ps

module ready_queue_scheduler_tb;
	import rqs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [1:0] kind;
		logic [9:0] start;
		logic [9:0] length;
	} sched_req_t;

	typedef struct packed {
		bit       issued;
		bit [9:0] addr;
		bit [7:0] pid;
		bit       done;
		bit       admit_ok;
		bit       empty;
	} sched_resp_t;

	typedef struct {
		bit [7:0] pid;
		bit [9:0] start;
		bit [9:0] len;
		bit [9:0] prog;
		bit [9:0] est;
	} proc_rec_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [23:0] m_axis_tdata;
	logic [4:0]  m_axis_tuser;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic        cfg_index = 0;
	logic [3:0]  cfg_data = '0;

	ready_queue_scheduler dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// queue model
	bit        live[QueueDepth];
	proc_rec_t procs[QueueDepth];
	int        rr_pos, slice_cnt, lock_pos;
	bit        locked;
	bit [1:0]  policy = POL_FCFS;
	bit [3:0]  quantum = 4'd2;

	sched_req_t  pending_reqs[$];
	sched_resp_t expected_resps[$];
	sched_req_t  offered;
	int          send_idle_pct, recv_stall_pct;
	int          mismatches, cycles;
	bit          hold_req, hold_taken;
	int          hold_left;

	function automatic int occupancy();
		int n = 0;
		while (n < QueueDepth && live[n])
			n++;
		return n;
	endfunction

	function automatic void drop_at(int r, int n);
		for (int i = r; i + 1 < n; i++) begin
			live[i] = live[i + 1];
			procs[i] = procs[i + 1];
		end
		if (n > 0)
			live[n - 1] = 0;
		if (rr_pos > r)
			rr_pos--;
		if (locked) begin
			if (lock_pos == r)
				locked = 0;
			else if (lock_pos > r)
				lock_pos--;
		end
	endfunction

	function automatic bit issue_at(int idx, ref sched_resp_t rsp);
		rsp.issued = 1;
		rsp.addr = procs[idx].start + procs[idx].prog;
		rsp.pid = procs[idx].pid;
		procs[idx].prog = procs[idx].prog + 1;
		return procs[idx].prog >= procs[idx].len;
	endfunction

	function automatic sched_resp_t schedule_item(sched_req_t rq);
		sched_resp_t rsp;
		int n, p, q, m;
		bit done;
		proc_rec_t hd, mv;
		rsp = '{default: 0};
		n = occupancy();
		if (rq.kind == KIND_ADMIT) begin
			if (n < QueueDepth && rq.length != 0) begin
				live[n] = 1;
				procs[n].pid = (n == 0) ? 8'd1 : procs[n - 1].pid + 8'd1;
				procs[n].start = rq.start;
				procs[n].len = rq.length;
				procs[n].prog = 0;
				procs[n].est = rq.length;
				rsp.pid = procs[n].pid;
				rsp.admit_ok = 1;
			end
		end else if (rq.kind == KIND_STEP && n > 0) begin
			case (policy)
				POL_FCFS: begin
					done = issue_at(0, rsp);
					if (done)
						drop_at(0, n);
				end
				POL_RR: begin
					q = (quantum == 0) ? 1 : quantum;
					if (rr_pos >= n) begin
						rr_pos = 0;
						slice_cnt = 0;
					end
					p = rr_pos;
					done = issue_at(p, rsp);
					if (done) begin
						drop_at(p, n);
						slice_cnt = 0;
						if (rr_pos >= n - 1)
							rr_pos = 0;
					end else begin
						slice_cnt = (slice_cnt + 1) & 15;
						if (slice_cnt >= q) begin
							slice_cnt = 0;
							rr_pos = (p + 1 >= n) ? 0 : p + 1;
						end
					end
				end
				POL_SJF: begin
					if (locked && lock_pos >= n)
						locked = 0;
					if (!locked) begin
						lock_pos = 0;
						for (int i = 1; i < n; i++)
							if (procs[i].len < procs[lock_pos].len)
								lock_pos = i;
						locked = 1;
					end
					p = lock_pos;
					done = issue_at(p, rsp);
					if (done)
						drop_at(p, n);
				end
				default: begin
					m = 0;
					for (int i = 1; i < n; i++)
						if (procs[i].est < procs[m].est)
							m = i;
					// promote the least estimate, old head goes to the tail
					if (m != 0) begin
						hd = procs[0];
						mv = procs[m];
						for (int i = m; i + 1 < n; i++)
							procs[i] = procs[i + 1];
						procs[n - 1] = hd;
						procs[0] = mv;
					end
					done = issue_at(0, rsp);
					if (done)
						drop_at(0, n);
					for (int i = 1; i < occupancy(); i++)
						if (procs[i].est > 0)
							procs[i].est--;
				end
			endcase
			rsp.done = done;
		end else if (rq.kind == KIND_ABORT) begin
			foreach (live[i])
				live[i] = 0;
			rr_pos = 0;
			slice_cnt = 0;
			locked = 0;
			lock_pos = 0;
		end
		rsp.empty = (occupancy() == 0);
		return rsp;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_resps.push_back(schedule_item(offered));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = pending_reqs.pop_front();
					s_axis_tvalid <= 1;
					s_axis_tdata <= {4'd0, offered.length, offered.start};
					s_axis_tuser <= offered.kind;
				end else begin
					s_axis_tvalid <= 0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		sched_resp_t want, got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.issued = m_axis_tuser[0];
			got.done = m_axis_tuser[1];
			got.admit_ok = m_axis_tuser[2];
			got.empty = m_axis_tuser[3];
			got.addr = m_axis_tdata[9:0];
			got.pid = m_axis_tdata[17:10];
			if (expected_resps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %p", got);
			end else begin
				want = expected_resps.pop_front();
				if (got != want || m_axis_tuser[4] !== 1'b0 || m_axis_tdata[23:18] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p (tdata %h tuser %h)",
							want, got, m_axis_tdata, m_axis_tuser);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("ready_queue_scheduler_tb NOT OK");
			$finish;
		end
	end

	task automatic push_req(logic [1:0] kind, logic [9:0] start, logic [9:0] length);
		pending_reqs.push_back('{kind: kind, start: start, length: length});
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || s_axis_tvalid || expected_resps.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [3:0] value);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 0;
		@(posedge clk);
		if (idx == CFG_POLICY)
			policy = value[1:0];
		else
			quantum = value;
	endtask

	task automatic run_phase(logic [1:0] pol, logic [3:0] qnt, int idle, int stall, int count);
		logic [1:0] kind;
		logic [9:0] len;
		int r;
		drain();
		write_reg(CFG_POLICY, {2'b00, pol});
		write_reg(CFG_QUANTUM, qnt);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			kind = (r < 42) ? KIND_ADMIT : (r < 94) ? KIND_STEP : (r < 97) ? KIND_ABORT : 2'd3;
			r = $urandom_range(99);
			len = (r < 5) ? 10'd0 : (r < 10) ? 10'($urandom) : 10'($urandom_range(1, 12));
			push_req(kind, 10'($urandom), len);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset policy (first come first served): edge cases
		push_req(KIND_STEP, '0, '0);
		push_req(KIND_ADMIT, 10'd5, 10'd0);
		push_req(KIND_ADMIT, 10'd1023, 10'd3);
		push_req(KIND_ADMIT, 10'd0, 10'd1023);
		for (int i = 0; i < 6; i++)
			push_req(KIND_ADMIT, 10'(i * 100), 10'd1);
		push_req(KIND_ADMIT, 10'd7, 10'd2);
		push_req(2'd3, 10'h3ff, 10'h3ff);
		for (int i = 0; i < 4; i++)
			push_req(KIND_STEP, '0, '0);
		push_req(KIND_ABORT, 10'h2aa, 10'h155);
		push_req(KIND_STEP, '0, '0);

		run_phase(POL_RR, 4'd1, 0, 0, 50);
		run_phase(POL_RR, 4'd15, 73, 0, 50);
		run_phase(POL_SJF, 4'd0, 0, 73, 50);
		run_phase(POL_AGING, 4'd3, 29, 29, 60);
		// back up the output with a long stall while items keep coming
		hold_req = 1;
		run_phase(POL_RR, 4'd0, 0, 0, 60);
		run_phase(POL_AGING, 4'd15, 0, 0, 50);
		run_phase(POL_FCFS, 4'd1, 29, 29, 40);
		run_phase(POL_SJF, 4'd2, 73, 0, 40);

		drain();
		if (mismatches == 0)
			$display("ready_queue_scheduler_tb OK");
		else
			$display("ready_queue_scheduler_tb NOT OK");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/rqs_pkg.sv
rtl/core/rqs_cell.sv
rtl/core/rqs_row.sv
rtl/core/ready_queue_scheduler.sv
rtl/core/rqs_checker.sv
dv/ready_queue_scheduler_tb.sv
